// ===== hw/rtl/tpic_pkg.sv =====
`timescale 1ns / 1ps

package tpic_pkg;

  // Filter order and history depth per channel
  localparam int FilterOrder = 3;
  localparam int NumChannels = 2;

  // Field widths
  localparam int SampleW = 12;
  localparam int YW      = 22;          // stored output, signed Q13.8
  localparam int FracW   = 8;
  localparam int CoefW   = 16;          // signed Q1.15
  localparam int CoefFrac = 15;
  localparam int AccW    = 40;          // Q.23 sum, exact
  localparam int BProdW  = CoefW + SampleW + 1;
  localparam int AProdW  = CoefW + YW;

  // Configuration port
  localparam int AddrW = 4;
  localparam int DataW = 32;

  localparam logic [1:0] RegXUpper = 2'd0;
  localparam logic [1:0] RegXLower = 2'd1;
  localparam logic [1:0] RegYUpper = 2'd2;
  localparam logic [1:0] RegYLower = 2'd3;

  localparam logic [SampleW-1:0] XUpperReset = 12'd2892;
  localparam logic [SampleW-1:0] XLowerReset = 12'd245;
  localparam logic [SampleW-1:0] YUpperReset = 12'd2530;
  localparam logic [SampleW-1:0] YLowerReset = 12'd358;

  // Feed-forward coefficients b0..b3
  localparam logic signed [CoefW-1:0] CoefB [FilterOrder+1] = '{
    16'sd3229, 16'sd9683, 16'sd9683, 16'sd3211
  };
  // Feedback coefficients a0..a3 (a0 unused)
  localparam logic signed [CoefW-1:0] CoefA [FilterOrder+1] = '{
    16'sh7fff, -16'sd18907, 16'sd13818, -16'sd1835
  };

  localparam logic signed [AccW-1:0] YMax = AccW'(64'sd2097151);
  localparam logic signed [AccW-1:0] YMin = -AccW'(64'sd2097152);

endpackage

// ===== hw/rtl/touch_position_iir_clamp.sv =====
`timescale 1ns / 1ps

// Two-channel touch position filter.
// Input channel (in_valid / in_stall, mode, sample): one raw ADC reading for
// the X axis (mode 0) or Y axis (mode 1). A transfer happens on a rising edge
// with in_valid high and in_stall low.
// Each sample runs through a third-order direct-form-I IIR filter that keeps
// separate input and output histories per axis, then is truncated to an
// integer and clamped to that axis' configured lower/upper limits.
// Output channel (out_valid / out_stall, channel, position): one result per
// input transfer, in order.
// The input register feeds the filter math and clamp into the result
// register. Throughput: one item per cycle while the receiver does not
// stall; the filter recursion closes within the single stage between the
// input register and the result register, which also advances the history.
// When the receiver stalls, the result register holds; the input register
// still accepts one more item, then in_stall rises until the result drains.
// Reset (rst, synchronous) clears both histories, empties both registers and
// loads the default limits. Limits are to be written by the user over the
// APB-style port at byte addresses 0, 4, 8, 12 (x_upper, x_lower, y_upper,
// y_lower) only while idle; the block itself does not enforce this.
module touch_position_iir_clamp
  import tpic_pkg::*;
(
  input  logic                clk,
  input  logic                rst,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic [SampleW-1:0]  sample,

  output logic                out_valid,
  input  logic                out_stall,
  output logic                channel,
  output logic [SampleW-1:0]  position,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready
);

  // Configuration registers
  logic [SampleW-1:0] x_upper, x_lower, y_upper, y_lower;

  // Input register
  logic               stage_valid;
  logic               stage_mode;
  logic [SampleW-1:0] stage_sample;

  // Per-axis histories: index 0 is the most recent
  logic [SampleW-1:0]        x_hist [NumChannels][FilterOrder];
  logic signed [YW-1:0]      y_hist [NumChannels][FilterOrder];

  logic                      advance;
  logic                      in_take;
  logic                      cfg_write;

  logic signed [BProdW-1:0]  b_prod [FilterOrder+1];
  logic signed [AProdW-1:0]  a_prod [FilterOrder+1];
  logic signed [AccW-1:0]    acc;
  logic signed [AccW-1:0]    y_floor;
  logic signed [YW-1:0]      y_next;
  logic [SampleW-1:0]        upper, lower;
  logic signed [YW-1:0]      upper_q, lower_q;
  logic [SampleW-1:0]        position_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Move the staged item into the result register whenever that slot is
  // free or being drained this cycle.
  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_upper <= XUpperReset;
      x_lower <= XLowerReset;
      y_upper <= YUpperReset;
      y_lower <= YLowerReset;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        RegXUpper: x_upper <= pwdata[SampleW-1:0];
        RegXLower: x_lower <= pwdata[SampleW-1:0];
        RegYUpper: y_upper <= pwdata[SampleW-1:0];
        RegYLower: y_lower <= pwdata[SampleW-1:0];
        default:   x_upper <= x_upper;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegXUpper: prdata = DataW'(x_upper);
      RegXLower: prdata = DataW'(x_lower);
      RegYUpper: prdata = DataW'(y_upper);
      RegYLower: prdata = DataW'(y_lower);
      default:   prdata = '0;
    endcase
  end

  // Input register: hold while the result side is blocked.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_mode   <= mode;
      stage_sample <= sample;
    end
  end

  // Filter: all products of the staged sample and its axis history, summed
  // exactly in Q.23.
  always_comb begin
    b_prod[0] = BProdW'(CoefB[0]) * BProdW'($signed({1'b0, stage_sample}));
    a_prod[0] = '0;
    for (int k = 1; k <= FilterOrder; k++) begin
      b_prod[k] = BProdW'(CoefB[k])
                * BProdW'($signed({1'b0, x_hist[stage_mode][k-1]}));
      a_prod[k] = AProdW'(CoefA[k]) * AProdW'(y_hist[stage_mode][k-1]);
    end
    acc = AccW'(b_prod[0]) <<< FracW;
    for (int k = 1; k <= FilterOrder; k++) begin
      acc = acc + (AccW'(b_prod[k]) <<< FracW) - AccW'(a_prod[k]);
    end
  end

  // Drop fraction bits with floor, then saturate to the stored Q13.8 range.
  always_comb begin
    y_floor = acc >>> CoefFrac;
    if (y_floor > YMax) begin
      y_next = YW'(YMax);
    end else if (y_floor < YMin) begin
      y_next = YW'(YMin);
    end else begin
      y_next = y_floor[YW-1:0];
    end
  end

  // Clamp: upper test first, so crossed limits give upper or lower only.
  always_comb begin
    upper   = stage_mode ? y_upper : x_upper;
    lower   = stage_mode ? y_lower : x_lower;
    upper_q = $signed({2'b00, upper, {FracW{1'b0}}});
    lower_q = $signed({2'b00, lower, {FracW{1'b0}}});
    if (y_next > upper_q) begin
      position_next = upper;
    end else if (y_next < lower_q) begin
      position_next = lower;
    end else begin
      position_next = y_next[FracW +: SampleW];
    end
  end

  // Advance the selected axis' histories as the item leaves the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NumChannels; c++) begin
        for (int k = 0; k < FilterOrder; k++) begin
          x_hist[c][k] <= '0;
          y_hist[c][k] <= '0;
        end
      end
    end else if (advance) begin
      for (int k = FilterOrder - 1; k > 0; k--) begin
        x_hist[stage_mode][k] <= x_hist[stage_mode][k-1];
        y_hist[stage_mode][k] <= y_hist[stage_mode][k-1];
      end
      x_hist[stage_mode][0] <= stage_sample;
      y_hist[stage_mode][0] <= y_next;
    end
  end

  // Result register: hold under stall, clear once the transfer is done.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      channel  <= stage_mode;
      position <= position_next;
    end
  end

endmodule
